// ===== hw/rtl/periodic_event_timer_table_defines.svh =====
// Assertion macros shared by the timer table RTL.
`ifndef PERIODIC_EVENT_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_EVENT_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while in reset.
`define PETT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while in reset.
`define PETT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pett_pkg.sv =====
// Shared constants, codes and types of the periodic event timer table.
package pett_pkg;

  // Default configuration.
  localparam int unsigned ENTRIES_DEF   = 64;
  localparam int unsigned TIME_BITS_DEF = 24;

  // At most this many fired beats are reported for one tick.
  localparam int unsigned MAX_OUT = 64;
  localparam int unsigned RPT_W   = $clog2(MAX_OUT + 1);

  // Payload field widths.
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned CMD_W  = 8;
  localparam int unsigned SECS_W = 24;
  localparam int unsigned KIND_W = 3;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_SET    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;
  // The request code that the block drops without an answer.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_SET_OK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_FAIL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOTFOUND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIRED    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_QUIET    = 3'd5;

  // Status of the controller, watched by the top level.
  typedef struct packed {
    logic busy;
    logic scan_active;
  } pett_status_t;

endpackage

// ===== hw/rtl/pett_req_if.sv =====
// Request channel: set, remove and tick beats.
interface pett_req_if;
  logic                        valid;
  logic                        ready;
  logic [pett_pkg::REQ_W-1:0]  req_type;
  logic [pett_pkg::CMD_W-1:0]  command;
  logic [pett_pkg::SECS_W-1:0] seconds;
  logic                        reload_mode;

  modport source (output valid, req_type, command, seconds, reload_mode, input ready);
  modport sink   (input valid, req_type, command, seconds, reload_mode, output ready);
endinterface

// ===== hw/rtl/pett_res_if.sv =====
// Result channel: one beat per answer or fired event.
interface pett_res_if;
  logic                        valid;
  logic                        ready;
  logic [pett_pkg::KIND_W-1:0] result_kind;
  logic [pett_pkg::CMD_W-1:0]  fired_command;
  logic                        last;

  modport source (output valid, result_kind, fired_command, last, input ready);
  modport sink   (input valid, result_kind, fired_command, last, output ready);
endinterface

// ===== hw/rtl/pett_mem.sv =====
// Entry memory with one write port, one registered read port and per-entry valid bits.
module pett_mem #(
  parameter int unsigned ENTRIES = pett_pkg::ENTRIES_DEF,
  parameter int unsigned IDX_W   = 6,
  parameter int unsigned ENT_W   = 57
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [ENT_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [ENT_W-1:0] wr_data_i
);

  logic [ENT_W-1:0]   mem_q [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  logic [ENT_W-1:0]   rd_data_q;
  logic               rd_vld_q;

  // Storage array, written at one address per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read of the payload.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits: an entry never written reads as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/pett_ctrl.sv =====
// Sequencer: scans the entry memory per request and drives the result register.
module pett_ctrl #(
  parameter int unsigned ENTRIES   = pett_pkg::ENTRIES_DEF,
  parameter int unsigned TIME_BITS = pett_pkg::TIME_BITS_DEF,
  parameter int unsigned IDX_W     = 6,
  parameter int unsigned ENT_W     = 57
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  pett_req_if.sink               req_i,
  pett_res_if.source             res_o,
  output logic                   rd_en_o,
  output logic [IDX_W-1:0]       rd_addr_o,
  input  logic [ENT_W-1:0]       rd_data_i,
  output logic                   wr_en_o,
  output logic [IDX_W-1:0]       wr_addr_o,
  output logic [ENT_W-1:0]       wr_data_o,
  output pett_pkg::pett_status_t status_o
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMD_W = pett_pkg::CMD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SETWR = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [pett_pkg::REQ_W-1:0]    op_q, op_d;
  logic [CMD_W-1:0]              cmd_q, cmd_d;
  logic [TIME_BITS-1:0]          secs_q, secs_d;
  logic                          mode_q, mode_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [CNT_W-1:0]              used_q, used_d;
  logic                          hit_q, hit_d;
  logic [IDX_W-1:0]              hit_idx_q, hit_idx_d;
  logic                          free_q, free_d;
  logic [IDX_W-1:0]              free_idx_q, free_idx_d;
  logic                          free_zero_q, free_zero_d;
  logic                          rm_found_q, rm_found_d;
  logic                          pend_vld_q, pend_vld_d;
  logic [CMD_W-1:0]              pend_cmd_q, pend_cmd_d;
  logic [pett_pkg::RPT_W-1:0]    rep_cnt_q, rep_cnt_d;
  logic [pett_pkg::KIND_W-1:0]   resp_kind_q, resp_kind_d;
  logic [CMD_W-1:0]              resp_cmd_q, resp_cmd_d;
  logic                          out_vld_q;
  logic [pett_pkg::KIND_W-1:0]   out_kind_q;
  logic [CMD_W-1:0]              out_cmd_q;
  logic                          out_last_q;

  logic                          accept, can_push, adv, at_last;
  logic [CMD_W-1:0]              e_cmd;
  logic [TIME_BITS-1:0]          e_rem, e_rel, dec, rem_new;
  logic                          e_mode, active, expire, report, stall, match;
  logic                          push, push_last;
  logic [pett_pkg::KIND_W-1:0]   push_kind;
  logic [CMD_W-1:0]              push_cmd;

  // Fields of the entry whose read data is present this cycle.
  assign e_cmd  = rd_data_i[CMD_W-1:0];
  assign e_rem  = rd_data_i[CMD_W +: TIME_BITS];
  assign e_rel  = rd_data_i[CMD_W+TIME_BITS +: TIME_BITS];
  assign e_mode = rd_data_i[CMD_W+2*TIME_BITS];

  // Per-entry tick arithmetic.
  assign active  = (e_cmd != '0) && (e_rem != '0);
  assign dec     = e_rem - TIME_BITS'(1);
  assign expire  = active && (dec == '0);
  assign rem_new = (expire && e_mode) ? e_rel : dec;
  assign report  = expire && (rep_cnt_q < pett_pkg::RPT_W'(pett_pkg::MAX_OUT));
  assign match   = (e_cmd == cmd_q);

  // The result register frees up when it is empty or its beat is taken.
  assign can_push = !out_vld_q || res_o.ready;
  assign stall    = (op_q == pett_pkg::REQ_TICK) && report && pend_vld_q && !can_push;
  assign adv      = (state_q == ST_SCAN) && !stall;
  assign at_last  = (idx_q == LAST_IDX);

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && (state_q == ST_IDLE);

  // Sequencer next state, memory accesses and result beats.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cmd_d       = cmd_q;
    secs_d      = secs_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    used_d      = used_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    free_zero_d = free_zero_q;
    rm_found_d  = rm_found_q;
    pend_vld_d  = pend_vld_q;
    pend_cmd_d  = pend_cmd_q;
    rep_cnt_d   = rep_cnt_q;
    resp_kind_d = resp_kind_q;
    resp_cmd_d  = resp_cmd_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = '0;
    wr_en_o     = 1'b0;
    wr_addr_o   = idx_q;
    wr_data_o   = '0;
    push        = 1'b0;
    push_kind   = pett_pkg::KIND_FIRED;
    push_cmd    = pend_cmd_q;
    push_last   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d        = req_i.req_type;
          cmd_d       = req_i.command;
          secs_d      = TIME_BITS'(req_i.seconds);
          mode_d      = req_i.reload_mode;
          idx_d       = '0;
          hit_d       = 1'b0;
          free_d      = 1'b0;
          rm_found_d  = 1'b0;
          pend_vld_d  = 1'b0;
          rep_cnt_d   = '0;
          resp_cmd_d  = '0;
          case (req_i.req_type)
            pett_pkg::REQ_SET: begin
              if (req_i.command == '0) begin
                resp_kind_d = pett_pkg::KIND_SET_FAIL;
                state_d     = ST_RESP;
              end else begin
                rd_en_o = 1'b1;
                state_d = ST_SCAN;
              end
            end
            pett_pkg::REQ_REMOVE: begin
              if (req_i.command == '0 || used_q == '0) begin
                resp_kind_d = pett_pkg::KIND_NOTFOUND;
                state_d     = ST_RESP;
              end else begin
                rd_en_o = 1'b1;
                state_d = ST_SCAN;
              end
            end
            pett_pkg::REQ_TICK: begin
              if (used_q == '0) begin
                resp_kind_d = pett_pkg::KIND_QUIET;
                state_d     = ST_RESP;
              end else begin
                rd_en_o = 1'b1;
                state_d = ST_SCAN;
              end
            end
            default: begin
              // Unused request code: no beat and no change.
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (adv) begin
          // Fetch the next entry while this one is handled.
          if (!at_last) begin
            rd_en_o   = 1'b1;
            rd_addr_o = idx_q + IDX_W'(1);
            idx_d     = idx_q + IDX_W'(1);
          end
          case (op_q)
            pett_pkg::REQ_SET: begin
              if (!hit_q && match) begin
                hit_d     = 1'b1;
                hit_idx_d = idx_q;
              end
              if (!free_q && e_rem == '0) begin
                free_d      = 1'b1;
                free_idx_d  = idx_q;
                free_zero_d = (e_cmd == '0);
              end
              if (at_last) begin
                state_d = ST_SETWR;
              end
            end
            pett_pkg::REQ_REMOVE: begin
              if (!rm_found_q && match) begin
                rm_found_d = 1'b1;
                wr_en_o    = 1'b1;
                wr_data_o  = {e_mode, e_rel, {TIME_BITS{1'b0}}, {CMD_W{1'b0}}};
                used_d     = used_q - CNT_W'(1);
              end
              if (at_last) begin
                resp_kind_d = (rm_found_q || match) ? pett_pkg::KIND_REMOVED
                                                    : pett_pkg::KIND_NOTFOUND;
                state_d     = ST_RESP;
              end
            end
            default: begin
              // Tick: count the entry down, reload or free it on expiry.
              if (active) begin
                wr_en_o   = 1'b1;
                wr_data_o = {e_mode, e_rel, rem_new,
                             (expire && !e_mode) ? {CMD_W{1'b0}} : e_cmd};
                if (expire && !e_mode && used_q != '0) begin
                  used_d = used_q - CNT_W'(1);
                end
              end
              if (report) begin
                push       = pend_vld_q;
                pend_vld_d = 1'b1;
                pend_cmd_d = e_cmd;
                rep_cnt_d  = rep_cnt_q + pett_pkg::RPT_W'(1);
              end
              if (at_last) begin
                if (report || pend_vld_q) begin
                  resp_kind_d = pett_pkg::KIND_FIRED;
                  resp_cmd_d  = report ? e_cmd : pend_cmd_q;
                end else begin
                  resp_kind_d = pett_pkg::KIND_QUIET;
                  resp_cmd_d  = '0;
                end
                state_d = ST_RESP;
              end
            end
          endcase
        end
      end

      ST_SETWR: begin
        // Update the matching entry, else take the first dormant one.
        if (hit_q || free_q) begin
          wr_en_o     = 1'b1;
          wr_addr_o   = hit_q ? hit_idx_q : free_idx_q;
          wr_data_o   = {mode_q, secs_q, secs_q, cmd_q};
          resp_kind_d = pett_pkg::KIND_SET_OK;
          if (!hit_q && free_zero_q) begin
            used_d = used_q + CNT_W'(1);
          end
        end else begin
          resp_kind_d = pett_pkg::KIND_SET_FAIL;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        // Final beat of the request.
        if (can_push) begin
          push      = 1'b1;
          push_kind = resp_kind_q;
          push_cmd  = resp_cmd_q;
          push_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      rm_found_q <= 1'b0;
      pend_vld_q <= 1'b0;
      rep_cnt_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      rm_found_q <= rm_found_d;
      pend_vld_q <= pend_vld_d;
      rep_cnt_q  <= rep_cnt_d;
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    cmd_q       <= cmd_d;
    secs_q      <= secs_d;
    mode_q      <= mode_d;
    idx_q       <= idx_d;
    hit_idx_q   <= hit_idx_d;
    free_idx_q  <= free_idx_d;
    free_zero_q <= free_zero_d;
    pend_cmd_q  <= pend_cmd_d;
    resp_kind_q <= resp_kind_d;
    resp_cmd_q  <= resp_cmd_d;
    if (push) begin
      out_kind_q <= push_kind;
      out_cmd_q  <= push_cmd;
      out_last_q <= push_last;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.result_kind   = out_kind_q;
  assign res_o.fired_command = out_cmd_q;
  assign res_o.last          = out_last_q;

  assign status_o.busy        = (state_q != ST_IDLE);
  assign status_o.scan_active = (state_q == ST_SCAN);

endmodule

// ===== hw/rtl/periodic_event_timer_table.sv =====
// Top level of the periodic event timer table.
//
// Requests enter on req_i (valid/ready); a beat is taken when both are high.
// A set or remove beat yields one result beat; a tick yields one fired beat
// per expired entry (up to 64) or a single "nothing fired" beat. The final
// beat of every request carries last = 1. Request code 3 is dropped silently.
// Each set, remove or tick with armed entries scans all ENTRIES memory words,
// one per cycle through the single read port unless the scan stalls (below).
// A set then passes through a write state before it presents its final
// beat; a remove or a tick presents its final beat straight after the scan.
// The next request can be taken once the final beat is in the output register.
// Requests that need no scan (command zero, or a remove or tick on an empty table) go straight to their beat.
// Only one request is worked on at a time; req_i.ready is high while idle.
// Results sit in an output register; while res_o is stalled the scan halts
// at an expired entry that finds the register and the held beat both taken,
// and every stalled cycle delays the request. A new request may be
// taken while the final beat still waits. Reset clears the entry valid bits
// and the counters at once, so every entry reads as empty without a clearing pass.
`include "periodic_event_timer_table_defines.svh"

module periodic_event_timer_table #(
  parameter int unsigned ENTRIES   = pett_pkg::ENTRIES_DEF,
  parameter int unsigned TIME_BITS = pett_pkg::TIME_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pett_req_if.sink   req_i,
  pett_res_if.source res_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned ENT_W = pett_pkg::CMD_W + 2 * TIME_BITS + 1;

  logic                   rd_en, wr_en;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  logic [ENT_W-1:0]       rd_data, wr_data;
  pett_pkg::pett_status_t stat;
  logic                   res_fired, res_quiet, res_cmd_nz, req_take;

  // Entry storage.
  pett_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .ENT_W   (ENT_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Request sequencer and result register.
  pett_ctrl #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W),
    .ENT_W     (ENT_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .res_o     (res_o),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .status_o  (stat)
  );

  // Beat qualifiers watched by the checks below.
  assign res_fired  = res_o.valid && (res_o.result_kind == pett_pkg::KIND_FIRED);
  assign res_quiet  = res_o.valid && (res_o.result_kind == pett_pkg::KIND_QUIET);
  assign res_cmd_nz = (res_o.fired_command != '0);
  assign req_take   = req_i.valid && req_i.ready && (req_i.req_type != pett_pkg::REQ_UNUSED);

  // No request is taken while the table is being scanned.
  `PETT_ASSERT_IMPL(a_no_accept_in_scan, stat.scan_active, !req_i.ready, "ready during scan")
  // A fired beat always names a real command.
  `PETT_ASSERT_IMPL(a_fired_has_cmd, res_fired, res_cmd_nz, "fired beat with command zero")
  // A quiet tick answer is a lone final beat without a command.
  `PETT_ASSERT_IMPL(a_quiet_is_last, res_quiet, res_o.last && !res_cmd_nz, "bad quiet tick beat")
  // An accepted request makes the sequencer busy next cycle unless it is dropped.
  `PETT_ASSERT_NEXT(a_accept_busy, req_take, stat.busy, "accepted request left sequencer idle")

endmodule
